>>> hdl/pcr_pkg.sv
// Shared constants, codes, command/status types and saturating helpers
// for the particle contact resolver. No dependencies.
`default_nettype none

package pcr_pkg;

    // default sizing
    localparam int PARTICLES_DEF = 64;
    localparam int CONTACTS_DEF  = 64;
    localparam int FRAC_BITS_DEF = 16;

    // configuration registers
    localparam int ITER_W = 10;
    localparam int STEP_W = 31;
    localparam logic [ITER_W-1:0] ITER_LIMIT_RST = 10'd8;
    localparam logic [STEP_W-1:0] STEP_DUR_RST   = 31'd1092;
    localparam logic CFG_ITERATION_LIMIT = 1'b0;
    localparam logic CFG_STEP_DURATION   = 1'b1;

    // item kinds
    localparam logic [1:0] KIND_WR_PART = 2'd0;
    localparam logic [1:0] KIND_WR_CONT = 2'd1;
    localparam logic [1:0] KIND_RUN     = 2'd2;
    localparam logic [1:0] KIND_RD_PART = 2'd3;

    // particle parts
    localparam logic [1:0] PART_POS   = 2'd0;
    localparam logic [1:0] PART_VEL   = 2'd1;
    localparam logic [1:0] PART_ACC   = 2'd2;
    localparam logic [1:0] PART_IMASS = 2'd3;
    // contact parts
    localparam logic [1:0] CPART_NORMAL  = 2'd0;
    localparam logic [1:0] CPART_SCALARS = 2'd1;

    // sequencer steps
    localparam logic [5:0] ST_IDLE     = 6'd0;
    localparam logic [5:0] ST_RD_OUT   = 6'd1;
    localparam logic [5:0] ST_RUN_DONE = 6'd2;
    localparam logic [5:0] ST_IT_START = 6'd3;
    localparam logic [5:0] ST_SC_RD    = 6'd4;
    localparam logic [5:0] ST_SC_LA    = 6'd5;
    localparam logic [5:0] ST_SC_LB    = 6'd6;
    localparam logic [5:0] ST_SC_LC    = 6'd7;
    localparam logic [5:0] ST_SC_REL   = 6'd8;
    localparam logic [5:0] ST_D0       = 6'd9;
    localparam logic [5:0] ST_D1       = 6'd10;
    localparam logic [5:0] ST_D2       = 6'd11;
    localparam logic [5:0] ST_D3       = 6'd12;
    localparam logic [5:0] ST_D4       = 6'd13;
    localparam logic [5:0] ST_SC_CMP   = 6'd14;
    localparam logic [5:0] ST_R_RD     = 6'd15;
    localparam logic [5:0] ST_R_LA     = 6'd16;
    localparam logic [5:0] ST_R_LB     = 6'd17;
    localparam logic [5:0] ST_R_LC     = 6'd18;
    localparam logic [5:0] ST_R_REL    = 6'd19;
    localparam logic [5:0] ST_M1       = 6'd20;
    localparam logic [5:0] ST_M2       = 6'd21;
    localparam logic [5:0] ST_M3       = 6'd22;
    localparam logic [5:0] ST_M4       = 6'd23;
    localparam logic [5:0] ST_M5       = 6'd24;
    localparam logic [5:0] ST_DIV_GO   = 6'd25;
    localparam logic [5:0] ST_DIV_WAIT = 6'd26;
    localparam logic [5:0] ST_V0       = 6'd27;
    localparam logic [5:0] ST_V1       = 6'd28;
    localparam logic [5:0] ST_V2       = 6'd29;
    localparam logic [5:0] ST_V3       = 6'd30;
    localparam logic [5:0] ST_AP_RD    = 6'd31;
    localparam logic [5:0] ST_AP_M0    = 6'd32;
    localparam logic [5:0] ST_AP_1     = 6'd33;
    localparam logic [5:0] ST_AP_2     = 6'd34;
    localparam logic [5:0] ST_AP_3     = 6'd35;
    localparam logic [5:0] ST_AP_WR    = 6'd36;
    localparam logic [5:0] ST_POS_CHK  = 6'd37;
    localparam logic [5:0] ST_ITER_END = 6'd38;

    // controller to datapath
    typedef struct packed {
        logic [5:0] step;
        logic       take;       // input beat accepted this cycle
        logic       tbl_pos;    // apply to position table, else velocity
        logic       second;     // apply to second particle
        logic       pos_phase;  // divide for positional correction
    } pcr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic       found;
        logic       two;
        logic       total_pos;
        logic       depth_pos;
        logic       div_done;
    } pcr_status_t;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fff_ffff;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] s;
        s = 64'(a) + 64'(b);
        return sat64(s);
    endfunction

    function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] s;
        s = 64'(a) - 64'(b);
        return sat64(s);
    endfunction

    function automatic logic signed [31:0] fx_neg(input logic signed [31:0] a);
        logic signed [63:0] s;
        s = 64'sd0 - 64'(a);
        return sat64(s);
    endfunction

endpackage

`default_nettype wire

>>> hdl/pcr_in_if.sv
// Input channel of the particle contact resolver: valid/ready plus one item.
// No dependencies.
`default_nettype none

interface pcr_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [6:0]         slot;
    logic [1:0]         part;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [31:0] z_value;
    logic [5:0]         first_particle;
    logic [5:0]         second_particle;
    logic               has_second;

    modport source (output valid, kind, slot, part, x_value, y_value, z_value,
                    first_particle, second_particle, has_second, input ready);
    modport sink (input valid, kind, slot, part, x_value, y_value, z_value,
                  first_particle, second_particle, has_second, output ready);
endinterface

`default_nettype wire

>>> hdl/pcr_out_if.sv
// Result channel of the particle contact resolver: valid/ready plus one result.
// No dependencies.
`default_nettype none

interface pcr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               is_read;

    modport source (output valid, out_x, out_y, out_z, is_read, input ready);
    modport sink (input valid, out_x, out_y, out_z, is_read, output ready);
endinterface

`default_nettype wire

>>> hdl/pcr_div.sv
// Bit-serial signed fixed-point divider: (a << FRAC_BITS) / b, b > 0,
// truncated toward zero, saturated to 32 bits. No dependencies.
`default_nettype none

module pcr_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] a,
    input  wire logic signed [31:0] b,
    output logic                    done,
    output logic signed [31:0]      q
);
    localparam int NW = 32 + FRAC_BITS;
    localparam int KW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] num_reg, num_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [31:0]   rem_reg, rem_next;
    logic          neg_reg, neg_next;
    logic signed [31:0] q_reg, q_next;

    logic [31:0] a_mag;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;

    always_comb
    begin
        a_mag   = a[31] ? (32'd0 - a) : a;
        rem_sh  = {rem_reg, num_reg[NW-1]};
        rem_sub = rem_sh - {1'b0, b};
    end

    // one quotient bit per cycle, then sign and saturate
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = NW'(a_mag) << FRAC_BITS;
            quo_next  = '0;
            rem_next  = '0;
            neg_next  = a[31];
        end
        else if (busy_reg && (cnt_reg != KW'(NW)))
        begin
            if (rem_sh >= {1'b0, b})
            begin
                rem_next = rem_sub[31:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[31:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            num_next = num_reg << 1;
            cnt_next = cnt_reg + KW'(1);
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
            if (neg_reg)
                q_next = (quo_reg > NW'(64'h8000_0000)) ? 32'sh8000_0000
                                                        : (32'd0 - quo_reg[31:0]);
            else
                q_next = (quo_reg > NW'(64'h7fff_ffff)) ? 32'sh7fff_ffff
                                                        : quo_reg[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

`default_nettype wire

>>> hdl/pcr_datapath.sv
// Datapath: particle and contact tables, shared multiplier, divider, scratch
// registers and the result register. Depends on pcr_pkg and pcr_div.
`default_nettype none

module pcr_datapath #(
    parameter int PARTICLES = pcr_pkg::PARTICLES_DEF,
    parameter int CONTACTS  = pcr_pkg::CONTACTS_DEF,
    parameter int FRAC_BITS = pcr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire pcr_pkg::pcr_cmd_t                cmd,
    input  wire logic [$clog2(CONTACTS+1)-1:0]    ci,
    output pcr_pkg::pcr_status_t                  status,
    output logic [$clog2(CONTACTS+1)-1:0]         count,
    input  wire logic [pcr_pkg::STEP_W-1:0]       step_duration,
    input  wire logic [1:0]                       kind,
    input  wire logic [6:0]                       slot,
    input  wire logic [1:0]                       part,
    input  wire logic signed [31:0]               x_value,
    input  wire logic signed [31:0]               y_value,
    input  wire logic signed [31:0]               z_value,
    input  wire logic [5:0]                       first_particle,
    input  wire logic [5:0]                       second_particle,
    input  wire logic                             has_second,
    output logic signed [31:0]                    out_x,
    output logic signed [31:0]                    out_y,
    output logic signed [31:0]                    out_z,
    output logic                                  is_read
);
    localparam int PW   = $clog2(PARTICLES);
    localparam int CW   = (CONTACTS > 1) ? $clog2(CONTACTS) : 1;
    localparam int CNTW = $clog2(CONTACTS + 1);
    localparam int SCW  = 65 + 2 * PW;

    // particle slot of a contact, reduced modulo PARTICLES
    function automatic logic [PW-1:0] mod_part(input logic [5:0] v);
        logic [31:0] t;
        t = 32'(v);
        for (int k = 5; k >= 0; k--)
        begin
            if (t >= (32'(PARTICLES) << k))
                t = t - (32'(PARTICLES) << k);
        end
        return PW'(t);
    endfunction

    // tables
    logic [95:0]    pos_mem   [PARTICLES];
    logic [95:0]    vel_mem   [PARTICLES];
    logic [95:0]    acc_mem   [PARTICLES];
    logic [31:0]    imass_mem [PARTICLES];
    logic [95:0]    cnorm_mem [CONTACTS];
    logic [SCW-1:0] cscal_mem [CONTACTS];

    logic [95:0]    pos_q, vel_q, acc_q, cnorm_q;
    logic [31:0]    imass_q;
    logic [SCW-1:0] cscal_q;

    // scratch registers
    logic [PW-1:0]      fa_reg, fb_reg;
    logic               two_reg;
    logic signed [31:0] n_reg [3];
    logic signed [31:0] vf_reg [3];
    logic signed [31:0] vs_reg [3];
    logic signed [31:0] rel_reg [3];
    logic signed [31:0] vec_reg [3];
    logic signed [31:0] tv_reg [3];
    logic signed [31:0] rest_reg, depth_reg, dot_reg, best_reg;
    logic signed [31:0] ima_reg, imb_reg, accsp_reg, nsep_reg, total_reg, q_reg;
    logic signed [63:0] acc64_reg, prod_reg;
    logic [CW-1:0]      pick_reg;
    logic               found_reg;
    logic [1:0]         part_reg;
    logic               rd_inr_reg;
    logic signed [31:0] ox_reg, oy_reg, oz_reg;
    logic               isr_reg;

    // decode and addressing
    logic               p_inr, c_inr;
    logic [PW-1:0]      p_slot, p_raddr, ap_p;
    logic [CW-1:0]      c_slot, c_raddr;
    logic signed [31:0] c_rest, c_depth;
    logic [PW-1:0]      c_first, c_second;
    logic               c_has;
    logic               ap_wr, wr_part, wr_cont;
    logic signed [31:0] ma, mb, w, mres, ns_sum;
    logic signed [63:0] shp;
    logic signed [31:0] div_a;
    logic               div_done;
    logic signed [31:0] div_q;
    logic               lt;

    always_comb
    begin
        p_inr    = 32'(slot) < 32'(PARTICLES);
        c_inr    = 32'(slot) < 32'(CONTACTS);
        p_slot   = PW'(slot);
        c_slot   = CW'(slot);
        c_rest   = cscal_q[31:0];
        c_depth  = cscal_q[63:32];
        c_first  = cscal_q[64 +: PW];
        c_second = cscal_q[64+PW +: PW];
        c_has    = cscal_q[64+2*PW];
        ap_p     = cmd.second ? fb_reg : fa_reg;
        ap_wr    = cmd.step == pcr_pkg::ST_AP_WR;
        wr_part  = cmd.take && (kind == pcr_pkg::KIND_WR_PART) && p_inr;
        wr_cont  = cmd.take && (kind == pcr_pkg::KIND_WR_CONT) && c_inr;
        w        = cmd.second ? pcr_pkg::fx_neg(imb_reg) : ima_reg;
        shp      = prod_reg >>> FRAC_BITS;
        mres     = pcr_pkg::sat64(shp);
        ns_sum   = pcr_pkg::fx_add(nsep_reg, mres);
        lt       = dot_reg < best_reg;
        div_a    = cmd.pos_phase ? pcr_pkg::fx_neg(depth_reg)
                                 : pcr_pkg::fx_sub(nsep_reg, best_reg);
    end

    // particle read address
    always_comb
    begin
        case (cmd.step)
            pcr_pkg::ST_SC_LA, pcr_pkg::ST_R_LA: p_raddr = c_first;
            pcr_pkg::ST_SC_LB, pcr_pkg::ST_R_LB: p_raddr = fb_reg;
            pcr_pkg::ST_AP_RD:                   p_raddr = ap_p;
            default:                             p_raddr = p_slot;
        endcase
        c_raddr = (cmd.step == pcr_pkg::ST_R_RD) ? pick_reg : ci[CW-1:0];
    end

    // table memories
    always_ff @(posedge clk)
    begin
        if ((wr_part && (part == pcr_pkg::PART_POS)) || (ap_wr && cmd.tbl_pos))
            pos_mem[ap_wr ? ap_p : p_slot] <= ap_wr ? {tv_reg[2], tv_reg[1], tv_reg[0]}
                                                    : {z_value, y_value, x_value};
        if ((wr_part && (part == pcr_pkg::PART_VEL)) || (ap_wr && !cmd.tbl_pos))
            vel_mem[ap_wr ? ap_p : p_slot] <= ap_wr ? {tv_reg[2], tv_reg[1], tv_reg[0]}
                                                    : {z_value, y_value, x_value};
        if (wr_part && (part == pcr_pkg::PART_ACC))
            acc_mem[p_slot] <= {z_value, y_value, x_value};
        if (wr_part && (part == pcr_pkg::PART_IMASS))
            imass_mem[p_slot] <= x_value;
        if (wr_cont && (part == pcr_pkg::CPART_NORMAL))
            cnorm_mem[c_slot] <= {z_value, y_value, x_value};
        if (wr_cont && (part == pcr_pkg::CPART_SCALARS))
            cscal_mem[c_slot] <= {has_second, mod_part(second_particle),
                                  mod_part(first_particle), y_value, x_value};
        pos_q   <= pos_mem[p_raddr];
        vel_q   <= vel_mem[p_raddr];
        acc_q   <= acc_mem[p_raddr];
        imass_q <= imass_mem[p_raddr];
        cnorm_q <= cnorm_mem[c_raddr];
        cscal_q <= cscal_mem[c_raddr];
    end

    // shared multiplier operands
    always_comb
    begin
        case (cmd.step)
            pcr_pkg::ST_D0:   begin ma = rel_reg[0]; mb = n_reg[0]; end
            pcr_pkg::ST_D1:   begin ma = rel_reg[1]; mb = n_reg[1]; end
            pcr_pkg::ST_D2:   begin ma = rel_reg[2]; mb = n_reg[2]; end
            pcr_pkg::ST_M1:   begin ma = dot_reg; mb = $signed({1'b0, step_duration}); end
            pcr_pkg::ST_M2:   begin ma = pcr_pkg::fx_neg(best_reg); mb = rest_reg; end
            pcr_pkg::ST_M3:   begin ma = rest_reg; mb = accsp_reg; end
            pcr_pkg::ST_V0:   begin ma = n_reg[0]; mb = q_reg; end
            pcr_pkg::ST_V1:   begin ma = n_reg[1]; mb = q_reg; end
            pcr_pkg::ST_V2:   begin ma = n_reg[2]; mb = q_reg; end
            pcr_pkg::ST_AP_M0: begin ma = vec_reg[0]; mb = w; end
            pcr_pkg::ST_AP_1: begin ma = vec_reg[1]; mb = w; end
            pcr_pkg::ST_AP_2: begin ma = vec_reg[2]; mb = w; end
            default:          begin ma = '0; mb = '0; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
    end

    // scratch register updates by step
    always_ff @(posedge clk)
    begin
        case (cmd.step)
            pcr_pkg::ST_SC_LA, pcr_pkg::ST_R_LA:
            begin
                for (int k = 0; k < 3; k++)
                    n_reg[k] <= cnorm_q[32*k +: 32];
                rest_reg  <= c_rest;
                depth_reg <= c_depth;
                fa_reg    <= c_first;
                fb_reg    <= c_second;
                two_reg   <= c_has;
            end
            pcr_pkg::ST_SC_LB:
            begin
                for (int k = 0; k < 3; k++)
                    vf_reg[k] <= vel_q[32*k +: 32];
            end
            pcr_pkg::ST_R_LB:
            begin
                for (int k = 0; k < 3; k++)
                    vf_reg[k] <= acc_q[32*k +: 32];
                ima_reg <= imass_q;
            end
            pcr_pkg::ST_SC_LC:
            begin
                for (int k = 0; k < 3; k++)
                    vs_reg[k] <= vel_q[32*k +: 32];
            end
            pcr_pkg::ST_R_LC:
            begin
                for (int k = 0; k < 3; k++)
                    vs_reg[k] <= acc_q[32*k +: 32];
                imb_reg <= imass_q;
            end
            pcr_pkg::ST_SC_REL, pcr_pkg::ST_R_REL:
            begin
                for (int k = 0; k < 3; k++)
                    rel_reg[k] <= two_reg ? pcr_pkg::fx_sub(vf_reg[k], vs_reg[k])
                                          : vf_reg[k];
            end
            pcr_pkg::ST_D0: acc64_reg <= '0;
            pcr_pkg::ST_D1, pcr_pkg::ST_D2, pcr_pkg::ST_D3: acc64_reg <= acc64_reg + shp;
            pcr_pkg::ST_D4: dot_reg <= pcr_pkg::sat64(acc64_reg);
            pcr_pkg::ST_M2: accsp_reg <= mres;
            pcr_pkg::ST_M3: nsep_reg <= mres;
            pcr_pkg::ST_M4:
            begin
                // resting contact: remove the velocity built up by acceleration
                if (accsp_reg < 0)
                    nsep_reg <= (ns_sum < 0) ? 32'sd0 : ns_sum;
                total_reg <= two_reg ? pcr_pkg::fx_add(ima_reg, imb_reg) : ima_reg;
            end
            pcr_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                    q_reg <= div_q;
            end
            pcr_pkg::ST_V1: vec_reg[0] <= mres;
            pcr_pkg::ST_V2: vec_reg[1] <= mres;
            pcr_pkg::ST_V3: vec_reg[2] <= mres;
            pcr_pkg::ST_AP_M0:
            begin
                for (int k = 0; k < 3; k++)
                    tv_reg[k] <= cmd.tbl_pos ? pos_q[32*k +: 32] : vel_q[32*k +: 32];
            end
            pcr_pkg::ST_AP_1: tv_reg[0] <= pcr_pkg::fx_add(mres, tv_reg[0]);
            pcr_pkg::ST_AP_2: tv_reg[1] <= pcr_pkg::fx_add(mres, tv_reg[1]);
            pcr_pkg::ST_AP_3: tv_reg[2] <= pcr_pkg::fx_add(mres, tv_reg[2]);
            default: ;
        endcase
    end

    // running minimum of separating velocity over the scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            best_reg  <= '0;
            pick_reg  <= '0;
        end
        else if (cmd.step == pcr_pkg::ST_IT_START)
        begin
            found_reg <= 1'b0;
            best_reg  <= '0;
        end
        else if ((cmd.step == pcr_pkg::ST_SC_CMP) && lt)
        begin
            found_reg <= 1'b1;
            best_reg  <= dot_reg;
            pick_reg  <= ci[CW-1:0];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            part_reg   <= part;
            rd_inr_reg <= p_inr;
        end
        if ((cmd.take && ((kind == pcr_pkg::KIND_WR_PART) ||
                          (kind == pcr_pkg::KIND_WR_CONT))) ||
            (cmd.step == pcr_pkg::ST_RUN_DONE))
        begin
            ox_reg  <= '0;
            oy_reg  <= '0;
            oz_reg  <= '0;
            isr_reg <= 1'b0;
        end
        else if (cmd.step == pcr_pkg::ST_RD_OUT)
        begin
            isr_reg <= 1'b1;
            ox_reg  <= '0;
            oy_reg  <= '0;
            oz_reg  <= '0;
            if (rd_inr_reg)
            begin
                case (part_reg)
                    pcr_pkg::PART_POS:
                        {oz_reg, oy_reg, ox_reg} <= pos_q;
                    pcr_pkg::PART_VEL:
                        {oz_reg, oy_reg, ox_reg} <= vel_q;
                    pcr_pkg::PART_ACC:
                        {oz_reg, oy_reg, ox_reg} <= acc_q;
                    default:
                        ox_reg <= imass_q;
                endcase
            end
        end
    end

    pcr_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.step == pcr_pkg::ST_DIV_GO),
        .a     (div_a),
        .b     (total_reg),
        .done  (div_done),
        .q     (div_q)
    );

    always_comb
    begin
        status.kind      = kind;
        status.found     = found_reg | lt;
        status.two       = two_reg;
        status.total_pos = total_reg > 0;
        status.depth_pos = depth_reg > 0;
        status.div_done  = div_done;
        count = (32'(slot) > 32'(CONTACTS)) ? CNTW'(CONTACTS) : CNTW'(slot);
    end

    assign out_x   = ox_reg;
    assign out_y   = oy_reg;
    assign out_z   = oz_reg;
    assign is_read = isr_reg;

endmodule

`default_nettype wire

>>> hdl/pcr_ctrl.sv
// Sequencer of the particle contact resolver: handshakes, iteration and
// contact counters, and the step sequence. Depends on pcr_pkg.
`default_nettype none

module pcr_ctrl #(
    parameter int CONTACTS = pcr_pkg::CONTACTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    input  wire logic [pcr_pkg::ITER_W-1:0]    iteration_limit,
    input  wire pcr_pkg::pcr_status_t          status,
    input  wire logic [$clog2(CONTACTS+1)-1:0] count,
    output pcr_pkg::pcr_cmd_t                  cmd,
    output logic [$clog2(CONTACTS+1)-1:0]      ci
);
    localparam int CNTW = $clog2(CONTACTS + 1);

    logic [5:0]                 state_reg, state_next;
    logic [pcr_pkg::ITER_W-1:0] it_reg, it_next;
    logic [CNTW-1:0]            ci_reg, ci_next;
    logic [CNTW-1:0]            cnt_reg, cnt_next;
    logic                       ov_reg, ov_next;
    logic                       tbl_pos_reg, tbl_pos_next;
    logic                       second_reg, second_next;
    logic                       pos_phase_reg, pos_phase_next;
    logic                       dot_ret_reg, dot_ret_next;
    logic                       take;

    assign in_ready = (state_reg == pcr_pkg::ST_IDLE) && (!ov_reg || out_ready);
    assign take     = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        it_next        = it_reg;
        ci_next        = ci_reg;
        cnt_next       = cnt_reg;
        tbl_pos_next   = tbl_pos_reg;
        second_next    = second_reg;
        pos_phase_next = pos_phase_reg;
        dot_ret_next   = dot_ret_reg;
        case (state_reg)
            pcr_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    case (status.kind)
                        pcr_pkg::KIND_RUN:
                        begin
                            it_next  = '0;
                            cnt_next = count;
                            if ((iteration_limit == '0) || (count == '0))
                                state_next = pcr_pkg::ST_RUN_DONE;
                            else
                                state_next = pcr_pkg::ST_IT_START;
                        end
                        pcr_pkg::KIND_RD_PART: state_next = pcr_pkg::ST_RD_OUT;
                        default:               state_next = pcr_pkg::ST_IDLE;
                    endcase
                end
            end
            pcr_pkg::ST_RD_OUT, pcr_pkg::ST_RUN_DONE: state_next = pcr_pkg::ST_IDLE;
            pcr_pkg::ST_IT_START:
            begin
                ci_next    = '0;
                state_next = pcr_pkg::ST_SC_RD;
            end
            // scan one contact
            pcr_pkg::ST_SC_RD:  state_next = pcr_pkg::ST_SC_LA;
            pcr_pkg::ST_SC_LA:  state_next = pcr_pkg::ST_SC_LB;
            pcr_pkg::ST_SC_LB:  state_next = pcr_pkg::ST_SC_LC;
            pcr_pkg::ST_SC_LC:  state_next = pcr_pkg::ST_SC_REL;
            pcr_pkg::ST_SC_REL:
            begin
                dot_ret_next = 1'b0;
                state_next   = pcr_pkg::ST_D0;
            end
            // dot product, shared by scan and resolve
            pcr_pkg::ST_D0: state_next = pcr_pkg::ST_D1;
            pcr_pkg::ST_D1: state_next = pcr_pkg::ST_D2;
            pcr_pkg::ST_D2: state_next = pcr_pkg::ST_D3;
            pcr_pkg::ST_D3: state_next = pcr_pkg::ST_D4;
            pcr_pkg::ST_D4: state_next = dot_ret_reg ? pcr_pkg::ST_M1 : pcr_pkg::ST_SC_CMP;
            pcr_pkg::ST_SC_CMP:
            begin
                if ((ci_reg + CNTW'(1)) < cnt_reg)
                begin
                    ci_next    = ci_reg + CNTW'(1);
                    state_next = pcr_pkg::ST_SC_RD;
                end
                else if (status.found)
                    state_next = pcr_pkg::ST_R_RD;
                else
                    state_next = pcr_pkg::ST_RUN_DONE;
            end
            // resolve the picked contact
            pcr_pkg::ST_R_RD: state_next = pcr_pkg::ST_R_LA;
            pcr_pkg::ST_R_LA: state_next = pcr_pkg::ST_R_LB;
            pcr_pkg::ST_R_LB: state_next = pcr_pkg::ST_R_LC;
            pcr_pkg::ST_R_LC: state_next = pcr_pkg::ST_R_REL;
            pcr_pkg::ST_R_REL:
            begin
                dot_ret_next = 1'b1;
                state_next   = pcr_pkg::ST_D0;
            end
            pcr_pkg::ST_M1: state_next = pcr_pkg::ST_M2;
            pcr_pkg::ST_M2: state_next = pcr_pkg::ST_M3;
            pcr_pkg::ST_M3: state_next = pcr_pkg::ST_M4;
            pcr_pkg::ST_M4: state_next = pcr_pkg::ST_M5;
            pcr_pkg::ST_M5:
            begin
                pos_phase_next = 1'b0;
                tbl_pos_next   = 1'b0;
                second_next    = 1'b0;
                state_next = status.total_pos ? pcr_pkg::ST_DIV_GO : pcr_pkg::ST_POS_CHK;
            end
            pcr_pkg::ST_DIV_GO: state_next = pcr_pkg::ST_DIV_WAIT;
            pcr_pkg::ST_DIV_WAIT:
            begin
                if (status.div_done)
                    state_next = pcr_pkg::ST_V0;
            end
            pcr_pkg::ST_V0:    state_next = pcr_pkg::ST_V1;
            pcr_pkg::ST_V1:    state_next = pcr_pkg::ST_V2;
            pcr_pkg::ST_V2:    state_next = pcr_pkg::ST_V3;
            pcr_pkg::ST_V3:    state_next = pcr_pkg::ST_AP_RD;
            pcr_pkg::ST_AP_RD: state_next = pcr_pkg::ST_AP_M0;
            pcr_pkg::ST_AP_M0: state_next = pcr_pkg::ST_AP_1;
            pcr_pkg::ST_AP_1:  state_next = pcr_pkg::ST_AP_2;
            pcr_pkg::ST_AP_2:  state_next = pcr_pkg::ST_AP_3;
            pcr_pkg::ST_AP_3:  state_next = pcr_pkg::ST_AP_WR;
            pcr_pkg::ST_AP_WR:
            begin
                if (!second_reg && status.two)
                begin
                    second_next = 1'b1;
                    state_next  = pcr_pkg::ST_AP_RD;
                end
                else if (!pos_phase_reg)
                    state_next = pcr_pkg::ST_POS_CHK;
                else
                    state_next = pcr_pkg::ST_ITER_END;
            end
            pcr_pkg::ST_POS_CHK:
            begin
                if (status.depth_pos && status.total_pos)
                begin
                    pos_phase_next = 1'b1;
                    tbl_pos_next   = 1'b1;
                    second_next    = 1'b0;
                    state_next     = pcr_pkg::ST_DIV_GO;
                end
                else
                    state_next = pcr_pkg::ST_ITER_END;
            end
            pcr_pkg::ST_ITER_END:
            begin
                if (({1'b0, it_reg} + 11'd1) < {1'b0, iteration_limit})
                begin
                    it_next    = it_reg + pcr_pkg::ITER_W'(1);
                    state_next = pcr_pkg::ST_IT_START;
                end
                else
                    state_next = pcr_pkg::ST_RUN_DONE;
            end
            default: state_next = pcr_pkg::ST_IDLE;
        endcase
    end

    // result valid: set when a result is loaded, cleared when taken
    always_comb
    begin
        if ((take && ((status.kind == pcr_pkg::KIND_WR_PART) ||
                      (status.kind == pcr_pkg::KIND_WR_CONT))) ||
            (state_reg == pcr_pkg::ST_RD_OUT) || (state_reg == pcr_pkg::ST_RUN_DONE))
            ov_next = 1'b1;
        else if (out_ready)
            ov_next = 1'b0;
        else
            ov_next = ov_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcr_pkg::ST_IDLE;
            it_reg        <= '0;
            ci_reg        <= '0;
            cnt_reg       <= '0;
            ov_reg        <= 1'b0;
            tbl_pos_reg   <= 1'b0;
            second_reg    <= 1'b0;
            pos_phase_reg <= 1'b0;
            dot_ret_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            it_reg        <= it_next;
            ci_reg        <= ci_next;
            cnt_reg       <= cnt_next;
            ov_reg        <= ov_next;
            tbl_pos_reg   <= tbl_pos_next;
            second_reg    <= second_next;
            pos_phase_reg <= pos_phase_next;
            dot_ret_reg   <= dot_ret_next;
        end
    end

    always_comb
    begin
        cmd.step      = state_reg;
        cmd.take      = take;
        cmd.tbl_pos   = tbl_pos_reg;
        cmd.second    = second_reg;
        cmd.pos_phase = pos_phase_reg;
    end

    assign ci        = ci_reg;
    assign out_valid = ov_reg;

endmodule

`default_nettype wire

>>> hdl/particle_contact_resolver.sv
// Particle contact resolver top level: configuration registers, sequencer
// and datapath. Depends on pcr_pkg, pcr_in_if, pcr_out_if, pcr_ctrl, pcr_datapath.
//
// Usage: items arrive on in_ch (valid/ready), one result beat per item leaves
// on out_ch. A beat is taken when valid and ready are both high. Particle and
// contact writes are acknowledged by a beat that is ready the next cycle;
// writes stream at one per cycle while out_ch keeps up. A particle read
// passes through the read-out step, which loads the result register, before
// its beat is raised. A run item walks the contacts for each iteration: each
// contact's relative velocity is dotted with its normal to find the most
// closing one, then come resolve steps plus up to two divides, on the shared
// multiplier and the bit-serial divider. A run ends early when no contact closes.
// in_ch.ready is low while a read or run is in progress, and while a result
// waits on a stalled out_ch; one result register parts the two sides.
// Reset returns the sequencer to idle with no result pending and sets the
// configuration registers to their defaults; table contents are undefined
// until written. The user must make configuration writes via cfg_we/cfg_index/
// cfg_data only while the block is idle; the block itself does not enforce it.
`default_nettype none

module particle_contact_resolver #(
    parameter int PARTICLES = pcr_pkg::PARTICLES_DEF,
    parameter int CONTACTS  = pcr_pkg::CONTACTS_DEF,
    parameter int FRAC_BITS = pcr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    pcr_in_if.sink                          in_ch,
    pcr_out_if.source                       out_ch,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [pcr_pkg::STEP_W-1:0] cfg_data
);
    localparam int CNTW = $clog2(CONTACTS + 1);

    logic [pcr_pkg::ITER_W-1:0] iter_limit_reg;
    logic [pcr_pkg::STEP_W-1:0] step_dur_reg;
    pcr_pkg::pcr_cmd_t          cmd;
    pcr_pkg::pcr_status_t       status;
    logic [CNTW-1:0]            count;
    logic [CNTW-1:0]            ci;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_limit_reg <= pcr_pkg::ITER_LIMIT_RST;
            step_dur_reg   <= pcr_pkg::STEP_DUR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pcr_pkg::CFG_ITERATION_LIMIT: iter_limit_reg <= cfg_data[pcr_pkg::ITER_W-1:0];
                default:                      step_dur_reg   <= cfg_data;
            endcase
        end
    end

    pcr_ctrl #(
        .CONTACTS(CONTACTS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_ch.valid),
        .in_ready        (in_ch.ready),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .iteration_limit (iter_limit_reg),
        .status          (status),
        .count           (count),
        .cmd             (cmd),
        .ci              (ci)
    );

    pcr_datapath #(
        .PARTICLES (PARTICLES),
        .CONTACTS  (CONTACTS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .ci              (ci),
        .status          (status),
        .count           (count),
        .step_duration   (step_dur_reg),
        .kind            (in_ch.kind),
        .slot            (in_ch.slot),
        .part            (in_ch.part),
        .x_value         (in_ch.x_value),
        .y_value         (in_ch.y_value),
        .z_value         (in_ch.z_value),
        .first_particle  (in_ch.first_particle),
        .second_particle (in_ch.second_particle),
        .has_second      (in_ch.has_second),
        .out_x           (out_ch.out_x),
        .out_y           (out_ch.out_y),
        .out_z           (out_ch.out_z),
        .is_read         (out_ch.is_read)
    );

endmodule

`default_nettype wire
